@@ hw/rtl/hfs_pkg.sv @@
// Package for the HMM forward scorer: sizes, item codes, command and status types.
// No dependencies.
package hfs_pkg;
	localparam int NUM_STATES  = 16;
	localparam int NUM_SYMBOLS = 64;
	localparam int PROB_BITS   = 16;
	localparam int SW = $clog2(NUM_STATES);
	localparam int YW = $clog2(NUM_SYMBOLS);
	localparam int SUMW = PROB_BITS + SW + 1;
	localparam int LN2_Q16 = 45426;

	localparam logic [1:0] KIND_INIT  = 2'd0;
	localparam logic [1:0] KIND_TRANS = 2'd1;
	localparam logic [1:0] KIND_EMIT  = 2'd2;
	localparam logic [1:0] KIND_OBS   = 2'd3;

	localparam logic [1:0] ST_WRITE = 2'd0;
	localparam logic [1:0] ST_SCORE = 2'd1;
	localparam logic [1:0] ST_ZERO  = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] row;
		logic [5:0] col;
		logic [15:0] prob;
		logic [5:0] symbol;
		logic start_req;
	} in_item_t;

	typedef struct packed {
		logic [31:0] log_prob;
		logic [1:0]  status;
		logic [15:0] time_index;
	} out_item_t;

	// Controller to datapath.
	typedef struct packed {
		logic        write_tbl;    // table write of the latched item
		logic        clr_acc;      // start phase of a term
		logic        mac;          // accumulate one transition product
		logic        fin_pred;     // saturate sum (init value on restart), weight by emission, store u[j]
		logic [SW-1:0] i;
		logic [SW-1:0] j;
		logic        div_start;
		logic        div_store;    // write quotient into vector entry j
		logic        ln_start;
		logic        commit;       // update counters/log with results
		logic        zero_commit;
		logic        restart;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic ln_done;
		logic scale_zero;
	} stat_t;
endpackage

@@ hw/rtl/hfs_if.sv @@
// Valid/ready channel carrying one payload of type T.
// No dependencies; the payload type comes in through the parameter.
interface hfs_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/hfs_ln.sv @@
// Iterative natural log in Q16.16 of x / 2^PROB_BITS, one squaring per cycle.
// Depends on hfs_pkg.
module hfs_ln import hfs_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [SUMW-1:0] x,
	output logic            done,
	output logic signed [31:0] result
);
	logic [1:0]  ph_q;        // 0 idle,1 squaring,2 scaling,3 done
	logic [32:0] y_q;
	logic [15:0] frac_q;
	logic [4:0]  k_q;
	logic signed [31:0] l2_q;
	logic [4:0]  e_c;
	logic [63:0] sq_c;
	logic [32:0] yn_c;
	logic [31:0] mag_c;
	logic [47:0] prod_q;
	logic        neg_q;

	always_comb begin
		e_c = '0;
		for (int b = 0; b < SUMW; b++)
			if (x[b]) e_c = 5'(b);
	end
	assign sq_c = 64'(y_q) * 64'(y_q);
	assign yn_c = 33'(sq_c >> 31);
	assign mag_c = l2_q[31] ? 32'(-l2_q) : 32'(l2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 2'd0;
			k_q  <= '0;
		end else begin
			unique case (ph_q)
				2'd0: if (start) begin
					ph_q <= 2'd1;
					k_q  <= '0;
				end
				2'd1: begin
					k_q <= k_q + 5'd1;
					if (k_q == 5'd15) ph_q <= 2'd2;
				end
				2'd2: ph_q <= 2'd3;
				default: ph_q <= 2'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == 2'd0 && start) begin
			y_q <= 33'({x, 31'd0} >> e_c);
			frac_q <= '0;
			l2_q <= 32'($signed({27'd0, e_c}) - PROB_BITS) <<< 16;
		end else if (ph_q == 2'd1) begin
			if (yn_c[32]) begin
				y_q <= yn_c >> 1;
				frac_q <= {frac_q[14:0], 1'b1};
			end else begin
				y_q <= yn_c;
				frac_q <= {frac_q[14:0], 1'b0};
			end
			if (k_q == 5'd15)
				l2_q <= l2_q + 32'({frac_q[14:0], yn_c[32]});
		end else if (ph_q == 2'd2) begin
			prod_q <= 48'(mag_c) * 48'(LN2_Q16) + 48'd32768;
			neg_q <= l2_q[31];
		end
	end

	assign done = (ph_q == 2'd3);
	assign result = neg_q ? -32'(prod_q >> 16) : 32'(prod_q >> 16);
endmodule

@@ hw/rtl/hfs_datapath.sv @@
// Datapath: tables, forward vector, shared MAC, restoring divider, log unit.
// Depends on hfs_pkg and hfs_ln.
module hfs_datapath import hfs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  item,
	input  cmd_t      cmd,
	output stat_t     st,
	output out_item_t res
);
	logic [PROB_BITS-1:0] init_mem [NUM_STATES];
	logic [PROB_BITS-1:0] trans_mem [NUM_STATES*NUM_STATES];
	logic [PROB_BITS-1:0] emit_mem [NUM_STATES*NUM_SYMBOLS];
	logic [PROB_BITS-1:0] fwd_q [NUM_STATES];
	logic [PROB_BITS-1:0] u_q [NUM_STATES];
	logic [PROB_BITS-1:0] trd_q, emd_q, ind_q;
	logic [SUMW-1:0] acc_q, scale_q;
	logic [PROB_BITS-1:0] sat_c;
	logic [2*PROB_BITS-1:0] pe_c, mp_c;
	logic emv_c;
	logic [SW+YW-1:0] eaddr;
	logic [SW-1:0] ti_c;
	logic signed [31:0] log_q;
	logic [15:0] cnt_q;
	logic [15:0] cnt_base;
	logic [1:0] status_q;
	// divider
	logic [2*PROB_BITS-1:0] num_q;
	logic [SUMW-1:0] rem_q;
	logic [PROB_BITS+SW:0] quo_q;
	logic [5:0] dk_q;
	logic dbusy_q;
	logic [SUMW:0] trial_c;
	logic ln_done;
	logic signed [31:0] ln_res;
	logic signed [32:0] sum_c;

	assign eaddr = {cmd.j, item.symbol[YW-1:0]};
	// fetch one row ahead while accumulating so the product sees row i
	assign ti_c = cmd.mac ? cmd.i + SW'(1) : cmd.i;
	always_ff @(posedge clk) begin
		if (cmd.write_tbl) begin
			unique case (item.kind)
				KIND_INIT: init_mem[item.row[SW-1:0]] <= item.prob[PROB_BITS-1:0];
				KIND_TRANS: if (item.col < 6'(NUM_STATES))
					trans_mem[{item.row[SW-1:0], item.col[SW-1:0]}] <= item.prob;
				KIND_EMIT: emit_mem[{item.row[SW-1:0], item.col[YW-1:0]}] <= item.prob;
				default: ;
			endcase
		end
		trd_q <= trans_mem[{ti_c, cmd.j}];
		emd_q <= emit_mem[eaddr];
		ind_q <= init_mem[cmd.j];
	end
	assign emv_c = 1'b1;

	assign mp_c = 32'(fwd_q[cmd.i]) * 32'(trd_q);
	assign sat_c = cmd.restart ? ind_q :
		(acc_q > SUMW'({PROB_BITS{1'b1}})) ? {PROB_BITS{1'b1}} : acc_q[PROB_BITS-1:0];
	assign pe_c = 32'(sat_c) * 32'(emd_q);

	always_ff @(posedge clk) begin
		if (cmd.clr_acc) acc_q <= '0;
		else if (cmd.mac) acc_q <= acc_q + SUMW'(mp_c >> PROB_BITS);
		if (cmd.clr_acc && cmd.j == '0) scale_q <= '0;
		if (cmd.fin_pred) begin
			u_q[cmd.j] <= pe_c[2*PROB_BITS-1:PROB_BITS] & {PROB_BITS{emv_c}};
			scale_q <= scale_q + SUMW'(pe_c[2*PROB_BITS-1:PROB_BITS]);
		end
	end

	assign trial_c = {rem_q, num_q[2*PROB_BITS-1]} ;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			dk_q <= '0;
		end else if (cmd.div_start) begin
			dbusy_q <= 1'b1;
			dk_q <= '0;
		end else if (dbusy_q) begin
			dk_q <= dk_q + 6'd1;
			if (dk_q == 6'(2*PROB_BITS-1)) dbusy_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			num_q <= {u_q[cmd.j], {PROB_BITS{1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
		end else if (dbusy_q) begin
			num_q <= num_q << 1;
			if (trial_c >= (SUMW+1)'(scale_q)) begin
				rem_q <= SUMW'(trial_c - (SUMW+1)'(scale_q));
				quo_q <= {quo_q[PROB_BITS+SW-1:0], 1'b1};
			end else begin
				rem_q <= SUMW'(trial_c);
				quo_q <= {quo_q[PROB_BITS+SW-1:0], 1'b0};
			end
		end
	end
	assign st.div_done = !dbusy_q && !cmd.div_start;
	assign st.scale_zero = (scale_q == '0);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_STATES; k++) fwd_q[k] <= '0;
		end else if (cmd.div_store) begin
			fwd_q[cmd.j] <= (quo_q > (PROB_BITS+SW+1)'({PROB_BITS{1'b1}})) ?
				{PROB_BITS{1'b1}} : quo_q[PROB_BITS-1:0];
		end
	end

	hfs_ln u_ln (.clk(clk), .arst_n(arst_n), .start(cmd.ln_start), .x(scale_q),
		.done(ln_done), .result(ln_res));
	assign st.ln_done = ln_done;

	assign cnt_base = cmd.restart ? 16'd0 : cnt_q;
	assign sum_c = 33'(log_q) + 33'(ln_res);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_q <= '0;
			cnt_q <= '0;
			status_q <= ST_WRITE;
		end else begin
			if (cmd.write_tbl) status_q <= ST_WRITE;
			if (cmd.zero_commit) begin
				log_q <= 32'sh8000_0000;
				cnt_q <= (cnt_base == 16'hFFFF) ? cnt_base : cnt_base + 16'd1;
				status_q <= ST_ZERO;
			end else if (cmd.commit) begin
				cnt_q <= (cnt_base == 16'hFFFF) ? cnt_base : cnt_base + 16'd1;
				status_q <= ST_SCORE;
				if (cmd.restart) log_q <= ln_res;
				else if (log_q != 32'sh8000_0000)
					log_q <= (sum_c < -33'sd2147483648) ? 32'sh8000_0000 :
						(sum_c > 33'sd2147483647) ? 32'sh7FFF_FFFF : 32'(sum_c);
			end
		end
	end
	assign res.log_prob = log_q;
	assign res.status = status_q;
	assign res.time_index = cnt_q;
endmodule

@@ hw/rtl/hfs_ctrl.sv @@
// Controller: sequences table writes, MAC sweep, division and log per item.
// Depends on hfs_pkg.
module hfs_ctrl import hfs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t item,
	input  logic     go,
	input  logic     out_taken,
	input  stat_t    st,
	output cmd_t     cmd,
	output logic     busy,
	output logic     out_valid
);
	localparam logic [3:0] S_IDLE = 4'd0, S_WR = 4'd1, S_RD = 4'd2, S_MAC = 4'd3,
		S_FIN = 4'd4, S_CHK = 4'd5, S_DST = 4'd6, S_DWT = 4'd7, S_LN = 4'd8,
		S_LNW = 4'd9, S_OUT = 4'd10, S_WRD = 4'd11;
	logic [3:0] state_q;
	logic [SW-1:0] i_q, j_q;
	logic restart_q, started_q, ovalid_q;
	logic last_i, last_j;
	assign last_i = (i_q == SW'(NUM_STATES-1));
	assign last_j = (j_q == SW'(NUM_STATES-1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q <= '0;
			j_q <= '0;
			restart_q <= 1'b0;
			started_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_taken) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (go) begin
					i_q <= '0;
					j_q <= '0;
					if (item.kind == KIND_OBS) begin
						restart_q <= item.start_req || !started_q;
						started_q <= 1'b1;
						state_q <= S_RD;
					end else state_q <= S_WR;
				end
				S_WR: state_q <= S_WRD;
				S_WRD: begin
					ovalid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RD: state_q <= restart_q ? S_FIN : S_MAC;
				S_MAC: begin
					i_q <= i_q + SW'(1);
					if (last_i) state_q <= S_FIN;
				end
				S_FIN: begin
					i_q <= '0;
					if (last_j) begin
						j_q <= '0;
						state_q <= S_CHK;
					end else begin
						j_q <= j_q + SW'(1);
						state_q <= S_RD;
					end
				end
				S_CHK: state_q <= st.scale_zero ? S_OUT : S_DST;
				S_DST: state_q <= S_DWT;
				S_DWT: if (st.div_done) begin
					if (last_j) state_q <= S_LN;
					else begin
						j_q <= j_q + SW'(1);
						state_q <= S_DST;
					end
				end
				S_LN: state_q <= S_LNW;
				S_LNW: if (st.ln_done) state_q <= S_OUT;
				S_OUT: begin
					ovalid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.i = i_q;
		cmd.j = j_q;
		cmd.restart = restart_q;
		cmd.write_tbl = (state_q == S_WR);
		cmd.clr_acc = (state_q == S_RD);
		cmd.mac = (state_q == S_MAC);
		cmd.fin_pred = (state_q == S_FIN);
		cmd.div_start = (state_q == S_DST);
		cmd.div_store = (state_q == S_DWT) && st.div_done;
		cmd.ln_start = (state_q == S_LN);
		cmd.commit = (state_q == S_LNW) && st.ln_done;
		cmd.zero_commit = (state_q == S_CHK) && st.scale_zero;
	end
	assign busy = (state_q != S_IDLE) || ovalid_q;
	assign out_valid = ovalid_q;
endmodule

@@ hw/rtl/hmm_forward_scorer_unit.sv @@
// HMM scaled forward scorer: one result per input item, one item at a time.
// A table write presents its result after the controller's S_WR and S_WRD states. For an
// observation the shared MAC walks 16x16 transition products, then a 32-step restoring
// divider runs once per state, then the log unit does its log2 squaring and scaling.
// A restart skips the MAC sweep; a zero scale skips the divider and the log. Input is
// taken again once the result has been taken. Depends on hfs_pkg, hfs_if, hfs_ctrl,
// hfs_datapath.
module hmm_forward_scorer_unit import hfs_pkg::*; (
	input logic clk,
	input logic arst_n,
	hfs_if.sink   in_ch,
	hfs_if.source out_ch
);
	in_item_t item_q;
	in_item_t ctrl_item;
	cmd_t cmd;
	stat_t st;
	logic busy, go;
	assign in_ch.ready = !busy;
	assign go = in_ch.valid && !busy;
	always_ff @(posedge clk) if (go) item_q <= in_ch.data;
	// decode the incoming transaction in the cycle it is accepted
	assign ctrl_item = go ? in_ch.data : item_q;

	hfs_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .item(ctrl_item), .go(go),
		.out_taken(out_ch.valid && out_ch.ready), .st(st), .cmd(cmd),
		.busy(busy), .out_valid(out_ch.valid));
	hfs_datapath u_dp (.clk(clk), .arst_n(arst_n), .item(item_q), .cmd(cmd),
		.st(st), .res(out_ch.data));
endmodule

@@ test/tb_top.sv @@
// Testbench for hmm_forward_scorer_unit: loads the model tables, scores symbol streams and
// checks every result against an in-bench scaled forward predictor.
// Depends on hfs_pkg, hfs_if and the scorer RTL.
`timescale 1ns / 100ps

module tb_top;
	import hfs_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #6 clk = ~clk;

	hfs_if #(.T(in_item_t))  in_ch (clk);
	hfs_if #(.T(out_item_t)) out_ch (clk);

	hmm_forward_scorer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	// predictor state
	logic [15:0] init_tbl [NUM_STATES];
	logic [15:0] trans_tbl [NUM_STATES*NUM_STATES];
	logic [15:0] emit_tbl [NUM_STATES*NUM_SYMBOLS];
	longint unsigned alpha [NUM_STATES];
	int          log_acc;
	int unsigned steps;
	bit          started;

	in_item_t  pending_items [$];
	out_item_t expected_results [$];
	int        errors;
	int        sent_cnt;
	bit        in_fire, out_fire;

	// ln(x / 2^16) in Q16.16
	function automatic longint ln_q16(longint unsigned x);
		int e;
		longint unsigned y;
		longint frac, l2, mag;
		e = 63;
		frac = 0;
		while (e > 0 && x[e] == 1'b0)
			e--;
		if (e >= 31)
			y = x >> (e - 31);
		else
			y = x << (31 - e);
		for (int k = 0; k < 16; k++) begin
			y = (y * y) >> 31;
			frac = frac << 1;
			if (y >= 64'h1_0000_0000) begin
				frac = frac | 1;
				y = y >> 1;
			end
		end
		l2 = (longint'(e) - PROB_BITS) * 65536 + frac;
		if (l2 < 0) begin
			mag = -l2;
			return -((mag * LN2_Q16 + 32768) >>> 16);
		end
		return (l2 * LN2_Q16 + 32768) >>> 16;
	endfunction

	function automatic out_item_t score_item(in_item_t it);
		out_item_t r;
		longint unsigned u [NUM_STATES];
		longint unsigned scale, p, em, a;
		longint s;
		bit restart;
		scale = 0;
		if (it.kind != KIND_OBS) begin
			if (it.kind == KIND_INIT)
				init_tbl[it.row] = it.prob;
			else if (it.kind == KIND_TRANS && it.col < NUM_STATES)
				trans_tbl[it.row*NUM_STATES + it.col] = it.prob;
			else if (it.kind == KIND_EMIT)
				emit_tbl[it.row*NUM_SYMBOLS + it.col] = it.prob;
			r.status = ST_WRITE;
		end else begin
			restart = it.start_req || !started;
			for (int j = 0; j < NUM_STATES; j++) begin
				em = emit_tbl[j*NUM_SYMBOLS + it.symbol];
				if (restart) begin
					p = init_tbl[j];
				end else begin
					p = 0;
					for (int i = 0; i < NUM_STATES; i++)
						p += (alpha[i] * trans_tbl[i*NUM_STATES + j]) >> PROB_BITS;
					if (p > 65535)
						p = 65535;
				end
				u[j] = (p * em) >> PROB_BITS;
				scale += u[j];
			end
			if (restart) begin
				log_acc = 0;
				steps = 0;
				started = 1'b1;
			end
			if (steps < 65535)
				steps++;
			if (scale == 0) begin
				log_acc = 32'h8000_0000;
				r.status = ST_ZERO;
			end else begin
				for (int j = 0; j < NUM_STATES; j++) begin
					a = (u[j] << PROB_BITS) / scale;
					alpha[j] = (a > 65535) ? 65535 : a;
				end
				if (log_acc != 32'h8000_0000) begin
					s = longint'(log_acc) + ln_q16(scale);
					if (s < -64'sd2147483648)
						s = -64'sd2147483648;
					if (s > 64'sd2147483647)
						s = 64'sd2147483647;
					log_acc = int'(s);
				end
				r.status = ST_SCORE;
			end
		end
		r.log_prob = log_acc;
		r.time_index = steps[15:0];
		return r;
	endfunction

	function automatic in_item_t make_item(logic [1:0] kind, int row, int col,
		int prob, int symbol, bit start);
		in_item_t it;
		it.kind = kind;
		it.row = 4'(row);
		it.col = 6'(col);
		it.prob = 16'(prob);
		it.symbol = 6'(symbol);
		it.start_req = start;
		return it;
	endfunction

	function automatic int rand_prob();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return 0;
		if (sel == 1)
			return 65535;
		return $urandom_range(0, 65535);
	endfunction

	// observed symbols stay on the emission columns that are loaded: 0-15 and 63
	function automatic logic [5:0] obs_symbol();
		if ($urandom_range(0, 16) == 16)
			return 6'd63;
		return 6'($urandom_range(0, 15));
	endfunction

	// idle percentages per phase: none, sender, receiver, both
	function automatic bit idle_now(bit sender_side);
		int ph;
		ph = (sent_cnt / 160) % 4;
		case (ph)
			1: return sender_side ? ($urandom_range(0, 99) < 47) : 1'b0;
			2: return sender_side ? 1'b0 : ($urandom_range(0, 99) < 47);
			3: return $urandom_range(0, 99) < 36;
			default: return 1'b0;
		endcase
	endfunction

	always @(posedge clk) begin
		in_fire <= in_ch.valid && in_ch.ready;
		out_fire <= out_ch.valid && out_ch.ready;
		if (arst_n && in_ch.valid && in_ch.ready)
			expected_results.push_back(score_item(in_ch.data));
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: log_prob %0d status %0d time_index %0d",
					$signed(out_ch.data.log_prob), out_ch.data.status,
					out_ch.data.time_index);
				errors++;
			end else begin
				out_item_t ex;
				ex = expected_results.pop_front();
				if (ex.log_prob !== out_ch.data.log_prob) begin
					$error("log_prob: expected %0d, actual %0d",
						$signed(ex.log_prob), $signed(out_ch.data.log_prob));
					errors++;
				end
				if (ex.status !== out_ch.data.status) begin
					$error("status: expected %0d, actual %0d",
						ex.status, out_ch.data.status);
					errors++;
				end
				if (ex.time_index !== out_ch.data.time_index) begin
					$error("time_index: expected %0d, actual %0d",
						ex.time_index, out_ch.data.time_index);
					errors++;
				end
			end
		end
	end

	// driver: hold valid until the transaction completes
	always @(negedge clk) begin
		if (arst_n) begin
			out_ch.ready <= !idle_now(1'b0);
			if (!in_ch.valid || in_fire) begin
				if (in_fire)
					sent_cnt++;
				if (pending_items.size() > 0 && !idle_now(1'b1)) begin
					in_ch.data <= pending_items.pop_front();
					in_ch.valid <= 1'b1;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		errors = 0;
		sent_cnt = 0;
		log_acc = 0;
		steps = 0;
		started = 1'b0;
		for (int i = 0; i < NUM_STATES; i++)
			alpha[i] = 0;

		// load every entry that an observation can read
		for (int i = 0; i < NUM_STATES; i++)
			pending_items.push_back(make_item(KIND_INIT, i, $urandom_range(0, 63),
				rand_prob() | 1, $urandom_range(0, 63), 1'($urandom_range(0, 1))));
		for (int i = 0; i < NUM_STATES*NUM_STATES; i++)
			pending_items.push_back(make_item(KIND_TRANS, i / NUM_STATES, i % NUM_STATES,
				rand_prob(), $urandom_range(0, 63), 1'($urandom_range(0, 1))));
		for (int j = 0; j < NUM_STATES; j++)
			for (int s = 0; s < 17; s++)
				pending_items.push_back(make_item(KIND_EMIT, j, (s == 16) ? 63 : s,
					rand_prob(), $urandom_range(0, 63), 1'($urandom_range(0, 1))));

		// directed: first observation restarts, extremes, ignored write, zero scale
		pending_items.push_back(make_item(KIND_OBS, 15, 63, 65535, 0, 1'b0));
		pending_items.push_back(make_item(KIND_OBS, 0, 0, 0, 63, 1'b0));
		pending_items.push_back(make_item(KIND_OBS, 0, 0, 0, 1, 1'b1));
		pending_items.push_back(make_item(KIND_TRANS, 3, 40, 65535, 7, 1'b1));
		pending_items.push_back(make_item(KIND_INIT, 0, 0, 65535, 0, 1'b0));
		pending_items.push_back(make_item(KIND_OBS, 0, 0, 0, 2, 1'b1));
		for (int j = 0; j < NUM_STATES; j++)
			pending_items.push_back(make_item(KIND_EMIT, j, 5, 0, 0, 1'b0));
		pending_items.push_back(make_item(KIND_OBS, 0, 0, 0, 5, 1'b0));
		pending_items.push_back(make_item(KIND_OBS, 0, 0, 0, 9, 1'b0));
		pending_items.push_back(make_item(KIND_OBS, 0, 0, 0, 9, 1'b1));

		// random: mostly observation runs with occasional table rewrites
		for (int n = 0; n < 730; n++) begin
			in_item_t it;
			it = 35'({$urandom(), $urandom()});
			if ($urandom_range(0, 99) < 72) begin
				it.kind = KIND_OBS;
				it.symbol = obs_symbol();
				it.start_req = ($urandom_range(0, 99) < 8);
			end else begin
				it.kind = 2'($urandom_range(0, 2));
				it.prob = 16'(rand_prob());
				if (it.kind == KIND_TRANS && $urandom_range(0, 3) != 0)
					it.col = 6'($urandom_range(0, NUM_STATES - 1));
			end
			pending_items.push_back(it);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_items.size() == 0 && !in_ch.valid && expected_results.size() == 0);
		repeat (600) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("TEST FAILED");
		$finish;
	end
endmodule
